// ----- src/lnr_pkg.sv -----
// ----------------------------------------------------------------------------
// lnr_pkg
// Shared types and codes for the eight-zone line rasterizer.
// ----------------------------------------------------------------------------
package lnr_pkg;

    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } op_t;

    typedef logic [2:0] zone_t;

    localparam zone_t ZONE_0 = 3'd0;
    localparam zone_t ZONE_1 = 3'd1;
    localparam zone_t ZONE_2 = 3'd2;
    localparam zone_t ZONE_3 = 3'd3;
    localparam zone_t ZONE_4 = 3'd4;
    localparam zone_t ZONE_5 = 3'd5;
    localparam zone_t ZONE_6 = 3'd6;
    localparam zone_t ZONE_7 = 3'd7;

endpackage

// ----- src/eight_zone_line_rasterizer.sv -----
// ----------------------------------------------------------------------------
// eight_zone_line_rasterizer
// Midpoint (Bresenham) line rasterizer covering all eight zones.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: a transaction with s_operation = OP_START carries two
//   endpoints and yields the first pixel. Each OP_STEP transaction yields
//   the next pixel along the line; m_last marks the second endpoint. A step
//   with no line in progress yields nothing. A start abandons any line in
//   progress.
//   Output channel m_*: one pixel per result transaction, with the line's
//   zone on m_octant.
//   An accepted transaction passes the input register, then the result
//   register, to m_valid. Throughput: one transaction per cycle unless stalled;
//   the step path is one add, one sign test and one unfold mux.
//   Reset (aresetn low, synchronous) empties both registers and drops any
//   line in progress.
//   Stall: while m_ready is low with a result held, one more transaction is
//   taken into the input register; if it yields a pixel, s_ready then falls
//   until the result register drains; nothing is dropped.
// ----------------------------------------------------------------------------
module eight_zone_line_rasterizer #(
    parameter int COORD_BITS = 11
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_operation,
    input  logic signed [COORD_BITS-1:0] s_start_x,
    input  logic signed [COORD_BITS-1:0] s_start_y,
    input  logic signed [COORD_BITS-1:0] s_end_x,
    input  logic signed [COORD_BITS-1:0] s_end_y,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [COORD_BITS-1:0] m_pixel_x,
    output logic signed [COORD_BITS-1:0] m_pixel_y,
    output logic [2:0]                   m_octant,
    output logic                         m_last
);
    import lnr_pkg::*;

    localparam int CW = COORD_BITS;

    logic                 in_valid_reg;
    op_t                  op_reg;
    logic signed [CW-1:0] sx_reg, sy_reg, ex_reg, ey_reg;

    logic                 out_valid_reg;
    logic signed [CW-1:0] out_x_reg, out_y_reg;
    zone_t                out_zone_reg;
    logic                 out_last_reg;

    zone_t                su_zone;
    logic signed [CW:0]   su_major, su_minor;
    logic [CW:0]          su_count;
    logic signed [CW+3:0] su_decision;
    logic signed [CW+2:0] su_straight, su_diagonal;

    logic                 active;
    logic                 produces;
    logic                 advance;
    logic                 res_valid;
    logic signed [CW-1:0] res_x, res_y;
    zone_t                res_zone;
    logic                 res_last;

    assign produces = (op_reg == OP_START) || active;
    assign advance  = in_valid_reg && (!produces || !out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            op_reg <= op_t'(s_operation);
            sx_reg <= s_start_x;
            sy_reg <= s_start_y;
            ex_reg <= s_end_x;
            ey_reg <= s_end_y;
        end
    end

    lnr_setup #(
        .CW (CW)
    ) u_setup (
        .start_x       (sx_reg),
        .start_y       (sy_reg),
        .end_x         (ex_reg),
        .end_y         (ey_reg),
        .zone          (su_zone),
        .major0        (su_major),
        .minor0        (su_minor),
        .count         (su_count),
        .decision0     (su_decision),
        .step_straight (su_straight),
        .step_diagonal (su_diagonal)
    );

    lnr_core #(
        .CW (CW)
    ) u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .item_valid     (advance),
        .op             (op_reg),
        .setup_zone     (su_zone),
        .setup_major    (su_major),
        .setup_minor    (su_minor),
        .setup_count    (su_count),
        .setup_decision (su_decision),
        .setup_straight (su_straight),
        .setup_diagonal (su_diagonal),
        .line_active    (active),
        .res_valid      (res_valid),
        .res_x          (res_x),
        .res_y          (res_y),
        .res_zone       (res_zone),
        .res_last       (res_last)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            out_x_reg    <= res_x;
            out_y_reg    <= res_y;
            out_zone_reg <= res_zone;
            out_last_reg <= res_last;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_pixel_x = out_x_reg;
    assign m_pixel_y = out_y_reg;
    assign m_octant  = out_zone_reg;
    assign m_last    = out_last_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> (!out_valid_reg || m_ready))
        else $error("result register overwritten while held");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_ready)
        else $error("input stalled with empty result register");

    a_held_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(op_reg) && $stable(sx_reg)))
        else $error("pending transaction lost or altered");

endmodule

// ----- src/lnr_setup.sv -----
// ----------------------------------------------------------------------------
// lnr_setup
// Line setup: zone classification, fold into zone 0, decision-variable init.
// ----------------------------------------------------------------------------
module lnr_setup #(
    parameter int CW = 11
) (
    input  logic signed [CW-1:0] start_x,
    input  logic signed [CW-1:0] start_y,
    input  logic signed [CW-1:0] end_x,
    input  logic signed [CW-1:0] end_y,
    output lnr_pkg::zone_t       zone,
    output logic signed [CW:0]   major0,
    output logic signed [CW:0]   minor0,
    output logic [CW:0]          count,
    output logic signed [CW+3:0] decision0,
    output logic signed [CW+2:0] step_straight,
    output logic signed [CW+2:0] step_diagonal
);
    import lnr_pkg::*;

    function automatic logic signed [CW:0] fold_a(
        input logic signed [CW:0] x,
        input logic signed [CW:0] y,
        input zone_t z
    );
        case (z)
            ZONE_0, ZONE_7: fold_a = x;
            ZONE_1, ZONE_2: fold_a = y;
            ZONE_3, ZONE_4: fold_a = -x;
            default:        fold_a = -y;
        endcase
    endfunction

    function automatic logic signed [CW:0] fold_b(
        input logic signed [CW:0] x,
        input logic signed [CW:0] y,
        input zone_t z
    );
        case (z)
            ZONE_0, ZONE_3: fold_b = y;
            ZONE_1, ZONE_6: fold_b = x;
            ZONE_4, ZONE_7: fold_b = -y;
            default:        fold_b = -x;
        endcase
    endfunction

    logic signed [CW:0]   x0_w, y0_w, dx, dy, ddx, ddy;
    logic [CW:0]          adx, ady;
    logic                 steep, xneg, yneg;
    logic signed [CW+2:0] ddx_w, ddy_w, diff_w;

    always_comb begin
        x0_w  = (CW+1)'(start_x);
        y0_w  = (CW+1)'(start_y);
        dx    = (CW+1)'(end_x) - x0_w;
        dy    = (CW+1)'(end_y) - y0_w;
        xneg  = dx[CW];
        yneg  = dy[CW];
        adx   = xneg ? (CW+1)'(-dx) : (CW+1)'(dx);
        ady   = yneg ? (CW+1)'(-dy) : (CW+1)'(dy);
        steep = adx < ady;

        if (!steep) begin
            if (!xneg && !yneg)  zone = ZONE_0;
            else if (!xneg)      zone = ZONE_7;
            else if (yneg)       zone = ZONE_4;
            else                 zone = ZONE_3;
        end else begin
            if (!xneg && !yneg)  zone = ZONE_1;
            else if (!xneg)      zone = ZONE_6;
            else if (yneg)       zone = ZONE_5;
            else                 zone = ZONE_2;
        end

        major0 = fold_a(x0_w, y0_w, zone);
        minor0 = fold_b(x0_w, y0_w, zone);
        ddx    = fold_a(dx, dy, zone);
        ddy    = fold_b(dx, dy, zone);
        count  = ddx;

        ddx_w         = (CW+3)'(ddx);
        ddy_w         = (CW+3)'(ddy);
        diff_w        = ddy_w - ddx_w;
        step_straight = ddy_w + ddy_w;
        step_diagonal = diff_w + diff_w;
        decision0     = (CW+4)'(step_straight) - (CW+4)'(ddx_w);
    end

endmodule

// ----- src/lnr_core.sv -----
// ----------------------------------------------------------------------------
// lnr_core
// Line state and per-pixel midpoint step, with unfold back to the line zone.
// ----------------------------------------------------------------------------
module lnr_core #(
    parameter int CW = 11
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 item_valid,
    input  lnr_pkg::op_t         op,
    input  lnr_pkg::zone_t       setup_zone,
    input  logic signed [CW:0]   setup_major,
    input  logic signed [CW:0]   setup_minor,
    input  logic [CW:0]          setup_count,
    input  logic signed [CW+3:0] setup_decision,
    input  logic signed [CW+2:0] setup_straight,
    input  logic signed [CW+2:0] setup_diagonal,
    output logic                 line_active,
    output logic                 res_valid,
    output logic signed [CW-1:0] res_x,
    output logic signed [CW-1:0] res_y,
    output lnr_pkg::zone_t       res_zone,
    output logic                 res_last
);
    import lnr_pkg::*;

    function automatic logic signed [CW:0] unfold_x(
        input logic signed [CW:0] a,
        input logic signed [CW:0] b,
        input zone_t z
    );
        case (z)
            ZONE_0, ZONE_7: unfold_x = a;
            ZONE_1, ZONE_6: unfold_x = b;
            ZONE_3, ZONE_4: unfold_x = -a;
            default:        unfold_x = -b;
        endcase
    endfunction

    function automatic logic signed [CW:0] unfold_y(
        input logic signed [CW:0] a,
        input logic signed [CW:0] b,
        input zone_t z
    );
        case (z)
            ZONE_0, ZONE_3: unfold_y = b;
            ZONE_1, ZONE_2: unfold_y = a;
            ZONE_4, ZONE_7: unfold_y = -b;
            default:        unfold_y = -a;
        endcase
    endfunction

    logic                 active_reg, active_next;
    zone_t                zone_reg, zone_next;
    logic signed [CW:0]   major_reg, major_next;
    logic signed [CW:0]   minor_reg, minor_next;
    logic signed [CW+3:0] decision_reg, decision_next;
    logic signed [CW+2:0] straight_reg, straight_next;
    logic signed [CW+2:0] diagonal_reg, diagonal_next;
    logic [CW:0]          left_reg, left_next;
    logic signed [CW:0]   px, py;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg   <= 1'b0;
            zone_reg     <= ZONE_0;
            major_reg    <= '0;
            minor_reg    <= '0;
            decision_reg <= '0;
            straight_reg <= '0;
            diagonal_reg <= '0;
            left_reg     <= '0;
        end else begin
            active_reg   <= active_next;
            zone_reg     <= zone_next;
            major_reg    <= major_next;
            minor_reg    <= minor_next;
            decision_reg <= decision_next;
            straight_reg <= straight_next;
            diagonal_reg <= diagonal_next;
            left_reg     <= left_next;
        end
    end

    always_comb begin
        active_next   = active_reg;
        zone_next     = zone_reg;
        major_next    = major_reg;
        minor_next    = minor_reg;
        decision_next = decision_reg;
        straight_next = straight_reg;
        diagonal_next = diagonal_reg;
        left_next     = left_reg;
        res_valid     = 1'b0;
        res_last      = 1'b0;

        if (item_valid) begin
            if (op == OP_START) begin
                zone_next     = setup_zone;
                major_next    = setup_major;
                minor_next    = setup_minor;
                decision_next = setup_decision;
                straight_next = setup_straight;
                diagonal_next = setup_diagonal;
                left_next     = setup_count;
                active_next   = setup_count != '0;
                res_valid     = 1'b1;
                res_last      = setup_count == '0;
            end else if (active_reg) begin
                major_next = major_reg + (CW+1)'(1);
                if (decision_reg[CW+3]) begin
                    decision_next = decision_reg + (CW+4)'(straight_reg);
                end else begin
                    decision_next = decision_reg + (CW+4)'(diagonal_reg);
                    minor_next    = minor_reg + (CW+1)'(1);
                end
                left_next   = left_reg - (CW+1)'(1);
                active_next = left_reg != (CW+1)'(1);
                res_valid   = 1'b1;
                res_last    = left_reg == (CW+1)'(1);
            end
        end

        px       = unfold_x(major_next, minor_next, zone_next);
        py       = unfold_y(major_next, minor_next, zone_next);
        res_x    = px[CW-1:0];
        res_y    = py[CW-1:0];
        res_zone = zone_next;
    end

    assign line_active = active_reg;

    a_active_count: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg == (left_reg != '0))
        else $error("line active flag disagrees with pixel count");

    a_step_signs: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (!straight_reg[CW+2] && (diagonal_reg[CW+2] || diagonal_reg == '0)))
        else $error("decision increments out of folded range");

    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_last) |=> !active_reg)
        else $error("line still active after last pixel");

endmodule

// ----- verif/eight_zone_line_rasterizer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eight_zone_line_rasterizer_tb
// Drives start and step transactions into the rasterizer and checks every
// pixel against an in-bench midpoint line predictor. Directed lines cover
// all eight zones, single-point lines, steps with no line, abandoned lines
// and the coordinate extremes. Random line sequences with random stalls on
// both channels follow.
// ----------------------------------------------------------------------------
module eight_zone_line_rasterizer_tb;

    import lnr_pkg::*;

    localparam int CB             = 11;
    localparam int TARGET_ITEMS   = 1850;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 20;

    typedef struct {
        op_t                 op;
        logic signed [CB-1:0] sx;
        logic signed [CB-1:0] sy;
        logic signed [CB-1:0] ex;
        logic signed [CB-1:0] ey;
        logic                drain;
    } line_cmd_t;

    typedef struct {
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
        zone_t               zone;
        logic                last;
    } pixel_t;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 s_valid     = 1'b0;
    logic                 s_ready;
    logic                 s_operation = 1'b0;
    logic signed [CB-1:0] s_start_x   = '0;
    logic signed [CB-1:0] s_start_y   = '0;
    logic signed [CB-1:0] s_end_x     = '0;
    logic signed [CB-1:0] s_end_y     = '0;
    logic                 m_valid;
    logic                 m_ready     = 1'b0;
    logic signed [CB-1:0] m_pixel_x;
    logic signed [CB-1:0] m_pixel_y;
    logic [2:0]           m_octant;
    logic                 m_last;

    line_cmd_t cmd_q[$];
    pixel_t    pixel_q[$];
    line_cmd_t cur_cmd;
    int        total_cmds;
    int        issued;
    int        fail_cnt;
    int        phase = 0;

    // predictor state
    logic                 line_on;
    zone_t                cur_zone;
    logic signed [CB:0]   maj_pos;
    logic signed [CB:0]   min_pos;
    logic signed [CB+3:0] dvar;
    logic signed [CB+2:0] inc_straight;
    logic signed [CB+2:0] inc_diag;
    logic [CB:0]          remain;

    eight_zone_line_rasterizer #(
        .COORD_BITS(CB)
    ) uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_operation(s_operation),
        .s_start_x  (s_start_x),
        .s_start_y  (s_start_y),
        .s_end_x    (s_end_x),
        .s_end_y    (s_end_y),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_pixel_x  (m_pixel_x),
        .m_pixel_y  (m_pixel_y),
        .m_octant   (m_octant),
        .m_last     (m_last)
    );

    always #5 aclk = ~aclk;

    function automatic int mag(input int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic zone_t classify_zone(input int dx, input int dy);
        if (mag(dx) >= mag(dy)) begin
            if (dx >= 0 && dy >= 0) return ZONE_0;
            if (dx >= 0) return ZONE_7;
            if (dy < 0) return ZONE_4;
            return ZONE_3;
        end
        if (dx >= 0 && dy >= 0) return ZONE_1;
        if (dx >= 0) return ZONE_6;
        if (dy < 0) return ZONE_5;
        return ZONE_2;
    endfunction

    function automatic void fold_pt(input int x, input int y, input zone_t z,
                                    output int a, output int b);
        case (z)
            ZONE_0: begin a = x;  b = y;  end
            ZONE_1: begin a = y;  b = x;  end
            ZONE_2: begin a = y;  b = -x; end
            ZONE_3: begin a = -x; b = y;  end
            ZONE_4: begin a = -x; b = -y; end
            ZONE_5: begin a = -y; b = -x; end
            ZONE_6: begin a = -y; b = x;  end
            default: begin a = x; b = -y; end
        endcase
    endfunction

    function automatic pixel_t unfold_pixel(input int a, input int b, input zone_t z,
                                            input logic is_last);
        pixel_t p;
        int     px;
        int     py;
        case (z)
            ZONE_0: begin px = a;  py = b;  end
            ZONE_1: begin px = b;  py = a;  end
            ZONE_2: begin px = -b; py = a;  end
            ZONE_3: begin px = -a; py = b;  end
            ZONE_4: begin px = -a; py = -b; end
            ZONE_5: begin px = -b; py = -a; end
            ZONE_6: begin px = b;  py = -a; end
            default: begin px = a; py = -b; end
        endcase
        p.x    = px[CB-1:0];
        p.y    = py[CB-1:0];
        p.zone = z;
        p.last = is_last;
        return p;
    endfunction

    task automatic predict_pixel(input line_cmd_t c);
        int a0, b0, a1, b1;
        int ddx, ddy;
        if (c.op == OP_START) begin
            cur_zone = classify_zone(int'(c.ex) - int'(c.sx), int'(c.ey) - int'(c.sy));
            fold_pt(c.sx, c.sy, cur_zone, a0, b0);
            fold_pt(c.ex, c.ey, cur_zone, a1, b1);
            ddx          = a1 - a0;
            ddy          = b1 - b0;
            maj_pos      = (CB+1)'(a0);
            min_pos      = (CB+1)'(b0);
            inc_straight = (CB+3)'(2 * ddy);
            inc_diag     = (CB+3)'(2 * (ddy - ddx));
            dvar         = (CB+4)'(2 * ddy - ddx);
            remain       = (CB+1)'(mag(ddx));
            line_on      = (remain != 0);
            pixel_q.push_back(unfold_pixel(maj_pos, min_pos, cur_zone, !line_on));
        end else if (line_on) begin
            maj_pos = maj_pos + (CB+1)'(1);
            if (dvar < 0) begin
                dvar = dvar + inc_straight;
            end else begin
                dvar    = dvar + inc_diag;
                min_pos = min_pos + (CB+1)'(1);
            end
            remain = remain - 1'b1;
            if (remain == 0) line_on = 1'b0;
            pixel_q.push_back(unfold_pixel(maj_pos, min_pos, cur_zone, !line_on));
        end
    endtask

    // ---------------- stimulus construction ----------------

    function automatic int rand_coord();
        return int'($urandom_range(0, 2047)) - 1024;
    endfunction

    function automatic int near_coord(input int base, input int span);
        int d;
        int v;
        d = int'($urandom_range(0, 2 * span)) - span;
        v = base + d;
        if (v > 1023 || v < -1024) v = base - d;
        return v;
    endfunction

    task automatic push_cmd(input op_t op, input int sx, input int sy, input int ex,
                            input int ey, input logic drain);
        line_cmd_t c;
        c.op    = op;
        c.sx    = sx[CB-1:0];
        c.sy    = sy[CB-1:0];
        c.ex    = ex[CB-1:0];
        c.ey    = ey[CB-1:0];
        c.drain = drain;
        cmd_q.push_back(c);
    endtask

    task automatic push_steps(input int n);
        repeat (n) push_cmd(OP_STEP, rand_coord(), rand_coord(), rand_coord(),
                            rand_coord(), 1'b0);
    endtask

    task automatic build_stimulus();
        int dzx[8] = '{1, 2, -2, -4, -5, -2, 2, 5};
        int dzy[8] = '{0, 5, 5, 4, -2, -5, -5, -2};
        int count;
        int r;
        int span;
        int x0, y0, x1, y1;
        int len;
        int nsteps;
        logic first;

        // step with no line in progress
        push_cmd(OP_STEP, 0, 0, 0, 0, 1'b0);
        // single-point lines at the corners
        push_cmd(OP_START, -1024, -1024, -1024, -1024, 1'b0);
        push_cmd(OP_START, 1023, 1023, 1023, 1023, 1'b0);
        // one short line per zone, each but the zone 0 line cut short by the next start
        for (int z = 0; z < 8; z++) begin
            push_cmd(OP_START, 100 - 30 * z, 50 * z - 200,
                     100 - 30 * z + dzx[z], 50 * z - 200 + dzy[z], 1'b0);
            push_steps(1);
        end
        // one more step on the zone 7 line before it is abandoned
        push_steps(1);
        // full-range diagonals, the second abandoning the first
        push_cmd(OP_START, -1024, 1023, 1023, -1024, 1'b0);
        push_steps(1);
        push_cmd(OP_START, 1023, -1024, -1024, 1023, 1'b0);
        push_steps(1);

        count = 0;
        first = 1'b1;
        while (count < TARGET_ITEMS) begin
            r = $urandom_range(0, 99);
            span = ($urandom_range(0, 99) < 80) ? 12 :
                   ($urandom_range(0, 99) < 90) ? 60 : 300;
            x0 = rand_coord();
            y0 = rand_coord();
            x1 = near_coord(x0, span);
            y1 = near_coord(y0, span);
            if (r >= 75 && r < 85) begin
                x1 = rand_coord();
                y1 = rand_coord();
            end
            len = (mag(x1 - x0) > mag(y1 - y0)) ? mag(x1 - x0) : mag(y1 - y0);
            if (r < 75) begin
                nsteps = len;
            end else if (r < 85) begin
                nsteps = (len > 0) ? $urandom_range(0, (len < 30) ? len - 1 : 30) : 0;
            end else if (r < 95) begin
                nsteps = len + $urandom_range(1, 3);
            end else begin
                x1 = x0;
                y1 = y0;
                len = 0;
                nsteps = $urandom_range(0, 3);
            end
            push_cmd(OP_START, x0, y0, x1, y1, first || ($urandom_range(0, 99) < 2));
            push_steps(nsteps);
            count += 1 + ((nsteps < len) ? nsteps : len);
            first = 1'b0;
        end
    endtask

    // ---------------- driver ----------------

    always @(posedge aclk) begin
        int send_idle;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) predict_pixel(cur_cmd);
            send_idle = (phase == 0) ? 7 : (phase == 1) ? 51 : 0;
            if (!s_valid || s_ready) begin
                if (cmd_q.size() > 0 && !(cmd_q[0].drain && pixel_q.size() > 0) &&
                    $urandom_range(0, 99) >= send_idle) begin
                    cur_cmd = cmd_q.pop_front();
                    s_valid     <= 1'b1;
                    s_operation <= cur_cmd.op;
                    s_start_x   <= cur_cmd.sx;
                    s_start_y   <= cur_cmd.sy;
                    s_end_x     <= cur_cmd.ex;
                    s_end_y     <= cur_cmd.ey;
                    issued++;
                    phase <= (issued * 3) / total_cmds;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------

    always @(posedge aclk) begin
        pixel_t want;
        int     recv_idle;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pixel_q.size() == 0) begin
                    $error("pixel transaction with none expected: x=%0d y=%0d",
                           m_pixel_x, m_pixel_y);
                    fail_cnt++;
                end else begin
                    want = pixel_q.pop_front();
                    if (m_pixel_x !== want.x) begin
                        $error("pixel_x: expected %0d, got %0d", want.x, m_pixel_x);
                        fail_cnt++;
                    end
                    if (m_pixel_y !== want.y) begin
                        $error("pixel_y: expected %0d, got %0d", want.y, m_pixel_y);
                        fail_cnt++;
                    end
                    if (m_octant !== want.zone) begin
                        $error("octant: expected %0d, got %0d", want.zone, m_octant);
                        fail_cnt++;
                    end
                    if (m_last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, m_last);
                        fail_cnt++;
                    end
                end
            end
            recv_idle = (phase == 0) ? 51 : (phase == 1) ? 7 : 0;
            m_ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    // ---------------- watchdog ----------------

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("** eight_zone_line_rasterizer: FAILED **");
        $finish;
    end

    // ---------------- sequence ----------------

    initial begin
        line_on      = 1'b0;
        cur_zone     = ZONE_0;
        maj_pos      = '0;
        min_pos      = '0;
        dvar         = '0;
        inc_straight = '0;
        inc_diag     = '0;
        remain       = '0;
        issued       = 0;
        fail_cnt     = 0;
        build_stimulus();
        total_cmds = cmd_q.size();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        while (cmd_q.size() != 0 || s_valid) @(posedge aclk);
        while (pixel_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_cnt == 0) begin
            $display("** eight_zone_line_rasterizer: PASSED **");
        end else begin
            $display("** eight_zone_line_rasterizer: FAILED **");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/lnr_pkg.sv
src/lnr_setup.sv
src/lnr_core.sv
src/eight_zone_line_rasterizer.sv
verif/eight_zone_line_rasterizer_tb.sv
